@@ rtl/fpa_pkg.sv @@
// Shared types and constants for the fixed-point ALU.
`timescale 1ns / 1ps
package fpa_pkg;

    // Working width for intermediate values; it holds every product and quotient.
    localparam int XW = 64;

    typedef enum logic [3:0] {
        ACT_ADD,
        ACT_SUB,
        ACT_MUL,
        ACT_DIV,
        ACT_GT,
        ACT_LT,
        ACT_GE,
        ACT_LE,
        ACT_EQ,
        ACT_NE,
        ACT_MIN,
        ACT_MAX,
        ACT_INC,
        ACT_DEC,
        ACT_TO_INT,
        ACT_FROM_INT
    } action_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_SAT,
        ST_DIV_ZERO
    } status_t;

    typedef struct packed {
        logic    vld;
        action_t act;
    } ctrl_t;

    typedef struct packed {
        logic    cmp;
        status_t st;
        logic    qneg;
        logic    dz;
    } flags_t;

endpackage

@@ rtl/fixed_point_alu_top.sv @@
// Top level of the fixed-point ALU: front stage, division cell chain, output stage.
// Each item passes through the front register, the NB division cells and the output register from start to done.
// Throughput: one item per cycle; the chain of division cells sets the latency.
// busy is always low and done is a single-cycle strobe; the receiver cannot stall.
// Reset clears every valid flag in the pipeline, so items in flight are dropped.
`timescale 1ns / 1ps
module fixed_point_alu_top #(
    parameter int FRAC_BITS = 8,
    parameter int WORD_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [3:0]         action,
    input  logic signed [31:0] operand_a,
    input  logic signed [31:0] operand_b,
    output logic               done,
    output logic signed [31:0] result,
    output logic               compare_true,
    output logic [1:0]         status
);
    import fpa_pkg::*;

    localparam int EW  = (WORD_BITS > 32) ? 32 : WORD_BITS;
    localparam int NB  = EW + FRAC_BITS;
    localparam int LAT = NB + 2;
    localparam logic [31:0] WMAX32 = 32'(signed'((XW'(1) << (EW - 1)) - XW'(1)));
    localparam logic [31:0] WMIN32 = ~WMAX32;

    ctrl_t                  ctrl_c  [NB+1];
    flags_t                 flags_c [NB+1];
    logic [31:0]            res_c   [NB+1];
    logic signed [2*EW-1:0] prod_c  [NB+1];
    logic [NB-1:0]          nq_c    [NB+1];
    logic [EW:0]            rem_c   [NB+1];
    logic [EW-1:0]          dv_c    [NB+1];

    assign busy     = 1'b0;
    assign rem_c[0] = '0;

    fpa_front #(.FB(FRAC_BITS), .EW(EW), .NB(NB)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .action    (action),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .ctrl      (ctrl_c[0]),
        .flags     (flags_c[0]),
        .res       (res_c[0]),
        .prod      (prod_c[0]),
        .nq        (nq_c[0]),
        .dv        (dv_c[0])
    );

    for (genvar i = 0; i < NB; i++)
    begin : g_cell
        fpa_cell #(.EW(EW), .NB(NB)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl_in   (ctrl_c[i]),
            .flags_in  (flags_c[i]),
            .res_in    (res_c[i]),
            .prod_in   (prod_c[i]),
            .nq_in     (nq_c[i]),
            .rem_in    (rem_c[i]),
            .dv_in     (dv_c[i]),
            .ctrl_out  (ctrl_c[i+1]),
            .flags_out (flags_c[i+1]),
            .res_out   (res_c[i+1]),
            .prod_out  (prod_c[i+1]),
            .nq_out    (nq_c[i+1]),
            .rem_out   (rem_c[i+1]),
            .dv_out    (dv_c[i+1])
        );
    end

    fpa_back #(.FB(FRAC_BITS), .EW(EW), .NB(NB)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl_in      (ctrl_c[NB]),
        .flags_in     (flags_c[NB]),
        .res_in       (res_c[NB]),
        .prod_in      (prod_c[NB]),
        .nq_in        (nq_c[NB]),
        .rem_in       (rem_c[NB]),
        .dv_in        (dv_c[NB]),
        .done         (done),
        .result       (result),
        .compare_true (compare_true),
        .status       (status)
    );

    // Every accepted item raises done once it has passed through the whole pipeline.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##(LAT) done)
        else $error("item did not complete after the pipeline latency");

    a_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_DIV_ZERO) |-> (result == WMAX32 || result == WMIN32))
        else $error("division by zero did not saturate");

    a_compare: assert property (@(posedge clk) disable iff (!rst_n)
        (done && compare_true) |-> (result == 32'd0 && status == ST_OK))
        else $error("comparison carried a result word or status");

endmodule

@@ rtl/fpa_front.sv @@
// Operand decode, the operations that need no division cells, multiplier and divider set-up.
`timescale 1ns / 1ps
module fpa_front #(
    parameter int FB = 8,
    parameter int EW = 32,
    parameter int NB = 40
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [3:0]             action,
    input  logic signed [31:0]     operand_a,
    input  logic signed [31:0]     operand_b,
    output fpa_pkg::ctrl_t         ctrl,
    output fpa_pkg::flags_t        flags,
    output logic [31:0]            res,
    output logic signed [2*EW-1:0] prod,
    output logic [NB-1:0]          nq,
    output logic [EW-1:0]          dv
);
    import fpa_pkg::*;

    localparam logic signed [XW-1:0] WMAX = signed'((XW'(1) << (EW - 1)) - XW'(1));
    localparam logic signed [XW-1:0] WMIN = -WMAX - XW'(1);

    logic signed [EW-1:0] a;
    logic signed [EW-1:0] b;
    logic signed [XW-1:0] a64;
    logic signed [XW-1:0] b64;
    logic [XW-1:0]        amag;
    logic [XW-1:0]        bmag;
    logic signed [XW-1:0] v;
    logic                 chk;
    action_t              act;
    ctrl_t                ctrl_reg, ctrl_next;
    flags_t               flags_reg, flags_next;
    logic [31:0]          res_reg, res_next;
    logic signed [2*EW-1:0] prod_reg, prod_next;
    logic [NB-1:0]        nq_reg, nq_next;
    logic [EW-1:0]        dv_reg, dv_next;

    always_comb
    begin
        a    = signed'(operand_a[EW-1:0]);
        b    = signed'(operand_b[EW-1:0]);
        a64  = XW'(a);
        b64  = XW'(b);
        amag = a64 < 0 ? unsigned'(-a64) : unsigned'(a64);
        bmag = b64 < 0 ? unsigned'(-b64) : unsigned'(b64);
        act  = action_t'(action);
        v    = '0;
        chk  = 1'b0;
        flags_next = '{cmp: 1'b0, st: ST_OK, qneg: a[EW-1] ^ b[EW-1], dz: (b == 0)};
        case (act)
            ACT_ADD:      begin v = a64 + b64;          chk = 1'b1; end
            ACT_SUB:      begin v = a64 - b64;          chk = 1'b1; end
            ACT_INC:      begin v = a64 + XW'(1);       chk = 1'b1; end
            ACT_DEC:      begin v = a64 - XW'(1);       chk = 1'b1; end
            ACT_FROM_INT: begin v = a64 <<< FB;         chk = 1'b1; end
            ACT_MUL:      v = '0;
            ACT_DIV:
            begin
                if (b == 0)
                begin
                    v = (a >= 0) ? WMAX : WMIN;
                    flags_next.st = ST_DIV_ZERO;
                end
            end
            ACT_GT:  flags_next.cmp = (a > b);
            ACT_LT:  flags_next.cmp = (a < b);
            ACT_GE:  flags_next.cmp = (a >= b);
            ACT_LE:  flags_next.cmp = (a <= b);
            ACT_EQ:  flags_next.cmp = (a == b);
            ACT_NE:  flags_next.cmp = (a != b);
            ACT_MIN: v = (a < b) ? a64 : b64;
            ACT_MAX: v = (a > b) ? a64 : b64;
            ACT_TO_INT:
            begin
                v = signed'(amag >> FB);
                if (a < 0)
                begin
                    v = -v;
                end
            end
            default: v = '0;
        endcase
        if (chk)
        begin
            if (v > WMAX)
            begin
                v = WMAX;
                flags_next.st = ST_SAT;
            end
            else if (v < WMIN)
            begin
                v = WMIN;
                flags_next.st = ST_SAT;
            end
        end
        res_next  = v[31:0];
        prod_next = a * b;
        nq_next   = NB'(amag << FB);
        dv_next   = bmag[EW-1:0];
        ctrl_next = '{vld: start, act: act};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flags_reg <= flags_next;
        res_reg   <= res_next;
        prod_reg  <= prod_next;
        nq_reg    <= nq_next;
        dv_reg    <= dv_next;
    end

    assign ctrl  = ctrl_reg;
    assign flags = flags_reg;
    assign res   = res_reg;
    assign prod  = prod_reg;
    assign nq    = nq_reg;
    assign dv    = dv_reg;

endmodule

@@ rtl/fpa_cell.sv @@
// One restoring-division cell: produces one quotient bit and passes the item on.
`timescale 1ns / 1ps
module fpa_cell #(
    parameter int EW = 32,
    parameter int NB = 40
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  fpa_pkg::ctrl_t         ctrl_in,
    input  fpa_pkg::flags_t        flags_in,
    input  logic [31:0]            res_in,
    input  logic signed [2*EW-1:0] prod_in,
    input  logic [NB-1:0]          nq_in,
    input  logic [EW:0]            rem_in,
    input  logic [EW-1:0]          dv_in,
    output fpa_pkg::ctrl_t         ctrl_out,
    output fpa_pkg::flags_t        flags_out,
    output logic [31:0]            res_out,
    output logic signed [2*EW-1:0] prod_out,
    output logic [NB-1:0]          nq_out,
    output logic [EW:0]            rem_out,
    output logic [EW-1:0]          dv_out
);
    import fpa_pkg::*;

    ctrl_t                  ctrl_reg;
    flags_t                 flags_reg;
    logic [31:0]            res_reg;
    logic signed [2*EW-1:0] prod_reg;
    logic [NB-1:0]          nq_reg, nq_next;
    logic [EW:0]            rem_reg, rem_next;
    logic [EW-1:0]          dv_reg;
    logic [EW:0]            trial;
    logic                   ge;

    // Unless the divisor is zero, the remainder stays below the divisor, so its top bit is clear.
    always_comb
    begin
        trial    = {rem_in[EW-1:0], nq_in[NB-1]};
        ge       = (trial >= {1'b0, dv_in});
        rem_next = ge ? (trial - {1'b0, dv_in}) : trial;
        nq_next  = {nq_in[NB-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        flags_reg <= flags_in;
        res_reg   <= res_in;
        prod_reg  <= prod_in;
        nq_reg    <= nq_next;
        rem_reg   <= rem_next;
        dv_reg    <= dv_in;
    end

    assign ctrl_out  = ctrl_reg;
    assign flags_out = flags_reg;
    assign res_out   = res_reg;
    assign prod_out  = prod_reg;
    assign nq_out    = nq_reg;
    assign rem_out   = rem_reg;
    assign dv_out    = dv_reg;

endmodule

@@ rtl/fpa_back.sv @@
// Rounding and saturation of products and quotients, and the result register.
`timescale 1ns / 1ps
module fpa_back #(
    parameter int FB = 8,
    parameter int EW = 32,
    parameter int NB = 40
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  fpa_pkg::ctrl_t         ctrl_in,
    input  fpa_pkg::flags_t        flags_in,
    input  logic [31:0]            res_in,
    input  logic signed [2*EW-1:0] prod_in,
    input  logic [NB-1:0]          nq_in,
    input  logic [EW:0]            rem_in,
    input  logic [EW-1:0]          dv_in,
    output logic                   done,
    output logic signed [31:0]     result,
    output logic                   compare_true,
    output logic [1:0]             status
);
    import fpa_pkg::*;

    localparam logic signed [XW-1:0] WMAX = signed'((XW'(1) << (EW - 1)) - XW'(1));
    localparam logic signed [XW-1:0] WMIN = -WMAX - XW'(1);
    localparam logic [XW-1:0]        HALF = XW'(1) << (FB - 1);

    logic signed [XW-1:0] p64;
    logic [XW-1:0]        pm;
    logic [XW-1:0]        qm;
    logic [XW-1:0]        qd;
    logic signed [XW-1:0] v;
    logic                 chk;
    status_t              st;
    logic                 done_reg, done_next;
    logic [31:0]          result_reg, result_next;
    logic                 cmp_reg, cmp_next;
    status_t              status_reg, status_next;

    always_comb
    begin
        p64 = XW'(prod_in);
        pm  = p64 < 0 ? unsigned'(-p64) : unsigned'(p64);
        qm  = (pm + HALF) >> FB;
        // Round the quotient up when twice the remainder reaches the divisor.
        qd  = XW'(nq_in) + XW'({rem_in, 1'b0} >= {2'b00, dv_in});
        v   = '0;
        chk = 1'b0;
        st  = flags_in.st;
        if (ctrl_in.act == ACT_MUL)
        begin
            v   = (p64 < 0) ? -signed'(qm) : signed'(qm);
            chk = 1'b1;
        end
        else if (ctrl_in.act == ACT_DIV && !flags_in.dz)
        begin
            v   = flags_in.qneg ? -signed'(qd) : signed'(qd);
            chk = 1'b1;
        end
        else
        begin
            v = XW'(signed'(res_in));
        end
        if (chk)
        begin
            if (v > WMAX)
            begin
                v  = WMAX;
                st = ST_SAT;
            end
            else if (v < WMIN)
            begin
                v  = WMIN;
                st = ST_SAT;
            end
        end
        done_next   = ctrl_in.vld;
        result_next = v[31:0];
        cmp_next    = flags_in.cmp;
        status_next = st;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        cmp_reg    <= cmp_next;
        status_reg <= status_next;
    end

    assign done         = done_reg;
    assign result       = signed'(result_reg);
    assign compare_true = cmp_reg;
    assign status       = status_reg;

endmodule
